// File: hdl/spqb_pkg.sv
// Shared types and constants of the sprite quad batcher.
// Used by spqb_dot and sprite_quad_batcher_top; depends on nothing.
package spqb_pkg;

  localparam int MaxTexturesDef = 32;
  localparam int StackDepthDef  = 16;
  localparam int MaxQuadsDef    = 8192;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_DRAW  = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ENTRY  = 2'd2;

  localparam logic [31:0] QOne = 32'h0001_0000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  elem_index;
    logic [31:0] matrix_value;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] size_x;
    logic [31:0] size_y;
    logic        has_texture;
    logic [31:0] texture_id;
    logic [31:0] color;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] vertex_x;
    logic [31:0] vertex_y;
    logic [31:0] vertex_z;
    logic [5:0]  tex_slot;
    logic [31:0] vertex_color;
    logic [31:0] bound_texture;
    logic [15:0] index_total;
    logic [5:0]  slot_total;
    logic        last;
  } out_t;

  // one product request into the dot unit
  typedef struct packed {
    logic        valid;
    logic [31:0] b;
    logic [3:0]  aidx;
    logic        first;
    logic        last;
    logic [3:0]  dest;
  } dot_req_t;

  typedef struct packed {
    logic        valid;
    logic [3:0]  dest;
    logic [31:0] value;
  } dot_res_t;

endpackage

// File: hdl/spqb_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module spqb_ram #(
  parameter int W = 32,
  parameter int D = 256
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/spqb_dot.sv
// Pipelined four-term Q16.16 dot product: multiply, accumulate, round and saturate.
// Depends on spqb_pkg; the A operand comes from the matrix RAM read port.
module spqb_dot (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spqb_pkg::dot_req_t req_i,
  input  logic              ident_i,
  input  logic [31:0]       rdata_i,
  output spqb_pkg::dot_res_t res_o,
  output logic              busy_o
);

  spqb_pkg::dot_req_t s1_q;
  logic        s2_vld_q, s2_first_q, s2_last_q;
  logic [3:0]  s2_dest_q;
  logic        s3_vld_q, s3_last_q;
  logic [3:0]  s3_dest_q;

  logic signed [31:0] a_op, b_op;
  logic signed [63:0] prod_d, prod_q;
  logic signed [65:0] acc_d, acc_q, rnd, shd;
  logic [31:0]        value;

  // base matrix is identity and never stored
  always_comb begin
    if (ident_i) begin
      a_op = (s1_q.aidx[3:2] == s1_q.aidx[1:0]) ? $signed(spqb_pkg::QOne) : 32'sd0;
    end else begin
      a_op = $signed(rdata_i);
    end
    b_op   = $signed(s1_q.b);
    prod_d = a_op * b_op;
    acc_d  = s2_first_q ? {{2{prod_q[63]}}, prod_q}
                        : acc_q + {{2{prod_q[63]}}, prod_q};
    rnd    = acc_q + 66'sd32768;
    shd    = rnd >>> 16;
    if (shd > 66'sd2147483647) begin
      value = 32'h7FFF_FFFF;
    end else if (shd < -66'sd2147483648) begin
      value = 32'h8000_0000;
    end else begin
      value = shd[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q     <= '0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_q     <= req_i;
      s2_vld_q <= s1_q.valid;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    s2_first_q <= s1_q.first;
    s2_last_q  <= s1_q.last;
    s2_dest_q  <= s1_q.dest;
    if (s2_vld_q) begin
      acc_q <= acc_d;
    end
    s3_last_q <= s2_last_q;
    s3_dest_q <= s2_dest_q;
  end

  assign res_o.valid = s3_vld_q && s3_last_q;
  assign res_o.dest  = s3_dest_q;
  assign res_o.value = value;
  assign busy_o      = s1_q.valid || s2_vld_q || s3_vld_q;

endmodule

// File: hdl/sprite_quad_batcher_top.sv
// Sprite quad batcher: matrix stack in RAM, texture slot table, batch flush.
// Depends on spqb_pkg, spqb_ram and spqb_dot.
//
// Input channel in_valid_i/in_stall_o carries one command beat (push element,
// pop, draw quad, flush). Output channel out_valid_o/out_stall_i carries result
// beats: vertices, flush headers and bound texture entries; last marks the
// final beat of a command. One command is worked at a time; in_stall_o is low
// only while the block is idle.
// Push element and pop are done in the idle state; the push of element 15
// runs 64 products through the single multiplier. A textured draw first runs
// a slot search; each vertex of a draw then runs 12 products and one output
// beat. A flush emits one beat per cycle while the output is not stalled.
// The matrix RAM read port sets the product rate.
// Reset: stack level one (identity base), no bound textures, index count zero.
// No clearing pass. A stalled output holds its beat; the engine waits on it,
// while the next command is taken as soon as the last beat is registered.
module sprite_quad_batcher_top #(
  parameter int MAX_TEXTURES = spqb_pkg::MaxTexturesDef,
  parameter int STACK_DEPTH  = spqb_pkg::StackDepthDef,
  parameter int MAX_QUADS    = spqb_pkg::MaxQuadsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  spqb_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output spqb_pkg::out_t out_data_o
);

  localparam int LW  = $clog2(STACK_DEPTH);
  localparam int SLW = $clog2(STACK_DEPTH + 1);
  localparam int CW  = $clog2(MAX_TEXTURES + 1);
  localparam int TW  = (MAX_TEXTURES > 1) ? $clog2(MAX_TEXTURES) : 1;
  localparam int LimitFull = MAX_QUADS * 6;
  localparam logic [15:0] IndexLimit = (LimitFull > 65535) ? 16'hFFFF : 16'(LimitFull);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_SEARCH   = 7'b0000010,
    ST_FL_HDR   = 7'b0000100,
    ST_FL_ENT   = 7'b0001000,
    ST_VTX_RUN  = 7'b0010000,
    ST_VTX_EMIT = 7'b0100000,
    ST_PUSH_RUN = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  logic [SLW-1:0]  level_q, level_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   i_q, i_d;
  logic [15:0]     idx_q, idx_d;
  logic [6:0]      job_q, job_d;
  logic [1:0]      vtx_q, vtx_d;
  logic            from_draw_q, from_draw_d;
  logic            out_valid_q, out_valid_d;

  spqb_pkg::out_t  out_q, out_d;
  logic [31:0]     staging_q [16];
  logic [31:0]     table_q [MAX_TEXTURES];
  logic [31:0]     tid_q, tid_d, color_q, color_d;
  logic [31:0]     px_q, px_d, py_q, py_d, qx_q, qx_d, qy_q, qy_d;
  logic [5:0]      slot_q, slot_d;
  logic [31:0]     res_x_q, res_y_q, res_z_q;

  logic            stg_we;
  logic            tbl_we;
  logic [TW-1:0]   tbl_waddr;
  logic            out_free, accept;

  // product issue
  spqb_pkg::dot_req_t req;
  spqb_pkg::dot_res_t res;
  logic            dot_busy;
  logic [6:0]      job_total;
  logic [3:0]      grp;
  logic [1:0]      jj, rr;
  logic [31:0]     vec_b, cx, cy;
  logic [LW-1:0]   top;
  logic [LW+3:0]   raddr, waddr;
  logic            ram_we;
  logic [31:0]     ram_rdata;
  logic            job_done;
  logic [16:0]     idx_sum;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic signed [32:0] s;
    s = $signed({a[31], a}) + $signed({b[31], b});
    if (s > 33'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (s < -33'sd2147483648) begin
      return 32'h8000_0000;
    end
    return s[31:0];
  endfunction

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign top       = LW'(level_q - SLW'(1));
  assign job_total = (state_q == ST_PUSH_RUN) ? 7'd64 : 7'd12;
  assign grp       = job_q[5:2];
  assign jj        = job_q[1:0];
  assign rr        = grp[1:0];
  assign cx        = (vtx_q == 2'd2 || vtx_q == 2'd3) ? qx_q : px_q;
  assign cy        = (vtx_q == 2'd1 || vtx_q == 2'd2) ? qy_q : py_q;

  always_comb begin
    case (jj)
      2'd0:    vec_b = cx;
      2'd1:    vec_b = cy;
      2'd2:    vec_b = '0;
      default: vec_b = spqb_pkg::QOne;
    endcase
  end

  always_comb begin
    req.valid = ((state_q == ST_PUSH_RUN) || (state_q == ST_VTX_RUN)) && (job_q < job_total);
    req.aidx  = {jj, rr};
    req.first = (jj == 2'd0);
    req.last  = (jj == 2'd3);
    req.dest  = grp;
    req.b     = (state_q == ST_PUSH_RUN) ? staging_q[{grp[3:2], jj}] : vec_b;
  end

  assign raddr    = {top, req.aidx};
  assign waddr    = {level_q[LW-1:0], res.dest};
  assign ram_we   = res.valid && (state_q == ST_PUSH_RUN);
  assign job_done = (job_q == job_total) && !dot_busy;
  assign idx_sum  = {1'b0, idx_q} + 17'd6;

  spqb_ram #(
    .W(32),
    .D(STACK_DEPTH * 16)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (res.value),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  spqb_dot u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .ident_i (top == '0),
    .rdata_i (ram_rdata),
    .res_o   (res),
    .busy_o  (dot_busy)
  );

  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    count_d     = count_q;
    i_d         = i_q;
    idx_d       = idx_q;
    job_d       = req.valid ? job_q + 7'd1 : job_q;
    vtx_d       = vtx_q;
    from_draw_d = from_draw_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    tid_d       = tid_q;
    color_d     = color_q;
    px_d        = px_q;
    py_d        = py_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    slot_d      = slot_q;
    stg_we      = 1'b0;
    tbl_we      = 1'b0;
    tbl_waddr   = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_data_i.opcode)
            spqb_pkg::OP_PUSH: begin
              stg_we = 1'b1;
              if (in_data_i.elem_index == 4'd15 && level_q < SLW'(STACK_DEPTH)) begin
                job_d   = '0;
                state_d = ST_PUSH_RUN;
              end
            end
            spqb_pkg::OP_POP: begin
              if (level_q > SLW'(1)) begin
                level_d = level_q - SLW'(1);
              end
            end
            spqb_pkg::OP_DRAW: begin
              px_d    = in_data_i.pos_x;
              py_d    = in_data_i.pos_y;
              qx_d    = sat_add(in_data_i.pos_x, in_data_i.size_x);
              qy_d    = sat_add(in_data_i.pos_y, in_data_i.size_y);
              tid_d   = in_data_i.texture_id;
              color_d = in_data_i.color;
              if (in_data_i.has_texture) begin
                i_d     = '0;
                state_d = ST_SEARCH;
              end else begin
                slot_d  = '0;
                vtx_d   = '0;
                job_d   = '0;
                state_d = ST_VTX_RUN;
              end
            end
            default: begin
              from_draw_d = 1'b0;
              state_d     = ST_FL_HDR;
            end
          endcase
        end
      end

      ST_SEARCH: begin
        if (i_q < count_q) begin
          if (table_q[i_q[TW-1:0]] == tid_q) begin
            slot_d  = 6'(i_q) + 6'd1;
            vtx_d   = '0;
            job_d   = '0;
            state_d = ST_VTX_RUN;
          end else begin
            i_d = i_q + CW'(1);
          end
        end else if (count_q >= CW'(MAX_TEXTURES)) begin
          from_draw_d = 1'b1;
          state_d     = ST_FL_HDR;
        end else begin
          tbl_we    = 1'b1;
          tbl_waddr = count_q[TW-1:0];
          count_d   = count_q + CW'(1);
          slot_d    = 6'(count_q) + 6'd1;
          vtx_d     = '0;
          job_d     = '0;
          state_d   = ST_VTX_RUN;
        end
      end

      ST_FL_HDR, ST_FL_ENT: begin
        if (out_free) begin
          logic fin;
          fin         = 1'b0;
          out_valid_d = 1'b1;
          out_d       = '0;
          if (state_q == ST_FL_HDR) begin
            out_d.kind        = spqb_pkg::KIND_HEADER;
            out_d.index_total = idx_q;
            out_d.slot_total  = 6'(count_q);
            fin               = (count_q == '0);
            i_d               = '0;
            state_d           = ST_FL_ENT;
          end else begin
            out_d.kind          = spqb_pkg::KIND_ENTRY;
            out_d.tex_slot      = 6'(i_q) + 6'd1;
            out_d.bound_texture = table_q[i_q[TW-1:0]];
            fin                 = (i_q == count_q - CW'(1));
            i_d                 = i_q + CW'(1);
          end
          out_d.last = fin && !from_draw_q;
          if (fin) begin
            idx_d = '0;
            if (from_draw_q) begin
              // table was full: rebind the pending handle in slot 1
              tbl_we    = 1'b1;
              tbl_waddr = '0;
              count_d   = CW'(1);
              slot_d    = 6'd1;
              vtx_d     = '0;
              job_d     = '0;
              state_d   = ST_VTX_RUN;
            end else begin
              count_d = '0;
              state_d = ST_IDLE;
            end
          end
        end
      end

      ST_VTX_RUN: begin
        if (job_done) begin
          state_d = ST_VTX_EMIT;
        end
      end

      ST_VTX_EMIT: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d              = '0;
          out_d.kind         = spqb_pkg::KIND_VERTEX;
          out_d.vertex_x     = res_x_q;
          out_d.vertex_y     = res_y_q;
          out_d.vertex_z     = res_z_q;
          out_d.tex_slot     = slot_q;
          out_d.vertex_color = color_q;
          out_d.last         = (vtx_q == 2'd3);
          if (vtx_q == 2'd3) begin
            idx_d   = (idx_sum > {1'b0, IndexLimit}) ? IndexLimit : idx_sum[15:0];
            state_d = ST_IDLE;
          end else begin
            vtx_d   = vtx_q + 2'd1;
            job_d   = '0;
            state_d = ST_VTX_RUN;
          end
        end
      end

      ST_PUSH_RUN: begin
        if (job_done) begin
          level_d = level_q + SLW'(1);
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      level_q     <= SLW'(1);
      count_q     <= '0;
      i_q         <= '0;
      idx_q       <= '0;
      job_q       <= '0;
      vtx_q       <= '0;
      from_draw_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      count_q     <= count_d;
      i_q         <= i_d;
      idx_q       <= idx_d;
      job_q       <= job_d;
      vtx_q       <= vtx_d;
      from_draw_q <= from_draw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    tid_q   <= tid_d;
    color_q <= color_d;
    px_q    <= px_d;
    py_q    <= py_d;
    qx_q    <= qx_d;
    qy_q    <= qy_d;
    slot_q  <= slot_d;
    if (stg_we) begin
      staging_q[in_data_i.elem_index] <= in_data_i.matrix_value;
    end
    if (tbl_we) begin
      table_q[tbl_waddr] <= tid_q;
    end
    if (res.valid && state_q == ST_VTX_RUN) begin
      case (res.dest[1:0])
        2'd0:    res_x_q <= res.value;
        2'd1:    res_y_q <= res.value;
        default: res_z_q <= res.value;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sim/tb_top.sv
// Self-checking bench for sprite_quad_batcher_top: matrix pushes, pops, draws and flushes.
// Depends on spqb_pkg and the RTL; a scoreboard class keeps its own copy of the batch state.
module tb_top;
  import spqb_pkg::*;

  localparam int NumTex   = MaxTexturesDef;
  localparam int NumStack = StackDepthDef;
  localparam int IdxLimit = (MaxQuadsDef * 6 > 65535) ? 65535 : MaxQuadsDef * 6;

  typedef logic signed [31:0] q16_t;
  typedef q16_t quad_t [4];

  class batch_scoreboard;
    q16_t        mstack [NumStack][16];
    int          level;
    q16_t        staged [16];
    logic [31:0] bound [NumTex];
    int          nbound;
    int          idx_count;
    out_t        pending [$];
    int          errors;
    int          n_beats;
    int          n_forced_flush;
    int          n_dropped_push;
    int          n_sat;

    function new();
      for (int m = 0; m < NumStack; m++)
        for (int i = 0; i < 16; i++) mstack[m][i] = '0;
      for (int i = 0; i < 4; i++) mstack[0][i * 5] = QOne;
      level = 1;
      nbound = 0;
      idx_count = 0;
      errors = 0;
    endfunction

    function void report(string msg);
      errors++;
      $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    function q16_t clamp(logic signed [66:0] v);
      if (v > 67'sh7fff_ffff) return 32'sh7fff_ffff;
      if (v < -67'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    // exact sum of four Q32.32 products, rounded half up to Q16.16
    function q16_t dot(quad_t a, quad_t b);
      logic signed [66:0] acc;
      logic signed [63:0] p;
      acc = '0;
      for (int i = 0; i < 4; i++) begin
        p = a[i] * b[i];
        acc += p;
      end
      return clamp((acc + 67'sd32768) >>> 16);
    endfunction

    function void flush_batch(ref out_t q [$]);
      out_t o;
      o = '0;
      o.kind = KIND_HEADER;
      o.index_total = idx_count[15:0];
      o.slot_total = nbound[5:0];
      q.push_back(o);
      for (int i = 0; i < nbound; i++) begin
        o = '0;
        o.kind = KIND_ENTRY;
        o.tex_slot = 6'(i + 1);
        o.bound_texture = bound[i];
        q.push_back(o);
      end
      idx_count = 0;
      nbound = 0;
    endfunction

    function void note_command(in_t d);
      out_t  q [$];
      out_t  o;
      quad_t a, b;
      q16_t  cx [4], cy [4];
      q16_t  px, py, qx, qy;
      int    slot;
      case (d.opcode)
        OP_PUSH: begin
          staged[d.elem_index] = d.matrix_value;
          if (d.elem_index == 4'd15) begin
            if (level >= NumStack) n_dropped_push++;
            else begin
              for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++) begin
                  for (int j = 0; j < 4; j++) begin
                    a[j] = mstack[level - 1][j * 4 + r];
                    b[j] = staged[c * 4 + j];
                  end
                  mstack[level][c * 4 + r] = dot(a, b);
                end
              level++;
            end
          end
        end
        OP_POP: if (level > 1) level--;
        OP_FLUSH: flush_batch(q);
        default: begin
          px = d.pos_x;
          py = d.pos_y;
          qx = clamp(67'(px) + 67'(signed'(d.size_x)));
          qy = clamp(67'(py) + 67'(signed'(d.size_y)));
          slot = 0;
          if (d.has_texture) begin
            for (int i = 0; i < nbound; i++)
              if (slot == 0 && bound[i] == d.texture_id) slot = i + 1;
            if (slot == 0) begin
              if (nbound >= NumTex) begin
                flush_batch(q);
                n_forced_flush++;
              end
              bound[nbound] = d.texture_id;
              nbound++;
              slot = nbound;
            end
          end
          cx = '{px, px, qx, qx};
          cy = '{py, qy, qy, py};
          for (int v = 0; v < 4; v++) begin
            o = '0;
            o.kind = KIND_VERTEX;
            o.tex_slot = slot[5:0];
            o.vertex_color = d.color;
            b = '{cx[v], cy[v], 32'sd0, QOne};
            for (int r = 0; r < 3; r++) begin
              a = '{mstack[level - 1][r], mstack[level - 1][4 + r],
                    mstack[level - 1][8 + r], mstack[level - 1][12 + r]};
              if (r == 0) o.vertex_x = dot(a, b);
              else if (r == 1) o.vertex_y = dot(a, b);
              else o.vertex_z = dot(a, b);
            end
            q.push_back(o);
          end
          if (idx_count + 6 >= IdxLimit) n_sat++;
          idx_count = (idx_count + 6 > IdxLimit) ? IdxLimit : idx_count + 6;
        end
      endcase
      if (q.size() > 0) begin
        q[q.size() - 1].last = 1'b1;
        foreach (q[i]) pending.push_back(q[i]);
      end
    endfunction

    function void cmp(string nm, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("beat %0d %s got %h want %h", n_beats, nm, got, want));
    endfunction

    function void check_beat(out_t g);
      out_t e;
      if (pending.size() == 0) begin
        report($sformatf("beat with nothing pending, kind %0d", g.kind));
        return;
      end
      e = pending.pop_front();
      cmp("kind", 32'(g.kind), 32'(e.kind));
      cmp("vertex_x", g.vertex_x, e.vertex_x);
      cmp("vertex_y", g.vertex_y, e.vertex_y);
      cmp("vertex_z", g.vertex_z, e.vertex_z);
      cmp("tex_slot", 32'(g.tex_slot), 32'(e.tex_slot));
      cmp("vertex_color", g.vertex_color, e.vertex_color);
      cmp("bound_texture", g.bound_texture, e.bound_texture);
      cmp("index_total", 32'(g.index_total), 32'(e.index_total));
      cmp("slot_total", 32'(g.slot_total), 32'(e.slot_total));
      cmp("last", 32'(g.last), 32'(e.last));
      n_beats++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  batch_scoreboard sb;
  int idle_pct;
  int stall_pct;
  int n_sent;
  bit hold_go;
  int hold_left;

  sprite_quad_batcher_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #(8 * 6_000_000);
    $display("tb_top failed");
    $finish;
  end

  // both sides sampled on pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_command(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_beat(out_data_o);
  end

  // receiver: random stall, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send(input in_t it);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_sent++;
  endtask

  function automatic in_t cmd(logic [1:0] op);
    in_t it;
    it = '0;
    it.opcode = op;
    return it;
  endfunction

  function automatic logic [31:0] small_q(int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // full 16-element push: near-affine, small random, or raw random
  task automatic push_matrix(input int style);
    in_t  it;
    q16_t m [16];
    for (int i = 0; i < 16; i++) m[i] = '0;
    if (style == 0) begin
      m[0] = small_q(32'h30000);
      m[5] = small_q(32'h30000);
      m[1] = small_q(32'h10000);
      m[4] = small_q(32'h10000);
      m[10] = QOne;
      m[15] = QOne;
      m[12] = small_q(32'h400000);
      m[13] = small_q(32'h400000);
    end else begin
      for (int i = 0; i < 16; i++)
        m[i] = (style == 1) ? small_q(32'h20000) : $urandom;
    end
    for (int i = 0; i < 16; i++) begin
      it = cmd(OP_PUSH);
      it.elem_index = 4'(i);
      it.matrix_value = m[i];
      send(it);
    end
  endtask

  function automatic in_t rand_draw(bit wide);
    in_t it;
    it = cmd(OP_DRAW);
    it.pos_x = wide ? $urandom : small_q(32'h1000000);
    it.pos_y = wide ? $urandom : small_q(32'h1000000);
    it.size_x = wide ? $urandom : $urandom_range(0, 32'h400000);
    it.size_y = wide ? $urandom : $urandom_range(0, 32'h400000);
    it.has_texture = ($urandom_range(99) < 75);
    it.texture_id = ($urandom_range(99) < 88) ? 32'h100 + $urandom_range(0, 39) : $urandom;
    it.color = $urandom;
    it.matrix_value = $urandom;
    it.elem_index = 4'($urandom);
    return it;
  endfunction

  task automatic random_phase(input int n_items);
    int   start;
    int   pick;
    in_t  it;
    start = n_sent;
    while (n_sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 50) send(rand_draw($urandom_range(99) < 12));
      else if (pick < 60) push_matrix($urandom_range(99) < 60 ? 0 : $urandom_range(1, 2));
      else if (pick < 72) send(cmd(OP_POP));
      else if (pick < 80) send(cmd(OP_FLUSH));
      else begin
        // stray element writes, an abandoned push
        it = cmd(OP_PUSH);
        it.elem_index = 4'($urandom_range(0, 14));
        it.matrix_value = $urandom;
        send(it);
      end
    end
  endtask

  initial begin
    in_t it;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    n_sent = 0;
    hold_go = 1'b0;
    hold_left = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: fill every staging element first, then the edge cases
    push_matrix(0);
    it = cmd(OP_DRAW);
    it.pos_x = 32'h7fff_ffff;
    it.pos_y = 32'h7fff_ffff;
    it.size_x = 32'h7fff_ffff;
    it.size_y = 32'h7fff_ffff;
    it.has_texture = 1'b1;
    it.texture_id = 32'hffff_ffff;
    it.color = 32'hffff_ffff;
    send(it);
    it.pos_x = 32'h8000_0000;
    it.pos_y = 32'h8000_0000;
    it.size_x = 32'h8000_0000;
    it.size_y = 32'h8000_0000;
    it.has_texture = 1'b0;
    it.texture_id = '0;
    it.color = '0;
    send(it);
    send(cmd(OP_POP));
    send(cmd(OP_POP));
    send(cmd(OP_FLUSH));
    send(cmd(OP_FLUSH));
    send(rand_draw(1'b0));

    // climb past the top of the stack on the staged matrix, then unwind below the base
    it = cmd(OP_PUSH);
    it.elem_index = 4'd15;
    it.matrix_value = QOne;
    for (int i = 0; i < NumStack + 1; i++) send(it);
    send(rand_draw(1'b0));
    for (int i = 0; i < NumStack + 1; i++) send(cmd(OP_POP));

    random_phase(100);
    idle_pct = 51;
    random_phase(100);
    idle_pct = 0;
    stall_pct = 51;
    hold_go = 1'b1;
    random_phase(100);
    idle_pct = 34;
    stall_pct = 34;
    random_phase(100);
    send(cmd(OP_FLUSH));

    in_valid_i <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("%0d commands, %0d result beats; %0d full-table flushes, %0d dropped pushes",
             n_sent, sb.n_beats, sb.n_forced_flush, sb.n_dropped_push);
    $display("index saturation hits %0d, mismatches %0d", sb.n_sat, sb.errors);
    if (sb.errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule

// File: files.f
hdl/spqb_pkg.sv
hdl/spqb_ram.sv
hdl/spqb_dot.sv
hdl/sprite_quad_batcher_top.sv
sim/tb_top.sv
